/* hdl/sorted_list_merge_engine_top_defines.svh */
// Assertion macros used by the top-level file.
`ifndef SORTED_LIST_MERGE_ENGINE_TOP_DEFINES_SVH
`define SORTED_LIST_MERGE_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTH
`define SLME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SLME_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SLME_ASSERT(lbl, prop, msg)
`define SLME_ASSERT_NR(lbl, prop, msg)
`endif

`endif

/* hdl/slme_pkg.sv */
`timescale 1ns / 1ps

package slme_pkg;

  localparam int unsigned LIST_DEPTH = 32;

  typedef enum logic [1:0] {
    CMD_APPEND_A = 2'd0,
    CMD_APPEND_B = 2'd1,
    CMD_MERGE    = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_MERGE = 1'b1
  } state_e;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [31:0] element_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] merged_value;
    logic               from_second;
    logic               last_of_run;
  } out_t;

  typedef struct packed {
    logic append_a;
    logic append_b;
    logic start;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic any_left;
    logic out_free;
    logic last_step;
  } dp_status_t;

endpackage

/* hdl/slme_ctrl.sv */
`timescale 1ns / 1ps

module slme_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  slme_pkg::cmd_e       in_cmd_i,
  output logic                 in_stall_o,
  input  slme_pkg::dp_status_t status_i,
  output slme_pkg::dp_cmd_t    cmd_o
);

  slme_pkg::state_e state_q, state_d;
  logic             accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slme_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != slme_pkg::ST_IDLE);
    accept     = in_valid_i && !in_stall_o;
    unique case (state_q)
      slme_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd_i)
            slme_pkg::CMD_APPEND_A: cmd_o.append_a = 1'b1;
            slme_pkg::CMD_APPEND_B: cmd_o.append_b = 1'b1;
            slme_pkg::CMD_MERGE: begin
              cmd_o.start = 1'b1;
              state_d     = slme_pkg::ST_MERGE;
            end
            default: ;
          endcase
        end
      end
      slme_pkg::ST_MERGE: begin
        if (!status_i.any_left) begin
          cmd_o.finish = 1'b1;
          state_d      = slme_pkg::ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.step = 1'b1;
        end
      end
      default: state_d = slme_pkg::ST_IDLE;
    endcase
  end

endmodule

/* hdl/slme_datapath.sv */
`timescale 1ns / 1ps

module slme_datapath #(
  parameter int unsigned LIST_DEPTH = slme_pkg::LIST_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic signed [31:0]   elem_i,
  input  slme_pkg::dp_cmd_t    cmd_i,
  output slme_pkg::dp_status_t status_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output slme_pkg::out_t       out_o
);

  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic signed [31:0] mem_a [LIST_DEPTH];
  logic signed [31:0] mem_b [LIST_DEPTH];
  logic signed [31:0] head_a_q, head_b_q;

  logic [CW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CW-1:0] ptr_a_q, ptr_a_d, ptr_b_q, ptr_b_d;
  logic [CW-1:0] ptr_a_nx, ptr_b_nx;
  logic          drop_q;
  logic          wr_a, wr_b;
  logic          has_a, has_b, take_a, take_b, sel_b;
  logic          out_valid_q, out_valid_d;
  slme_pkg::out_t out_q, res;

  assign wr_a  = cmd_i.append_a && (cnt_a_q != CW'(LIST_DEPTH));
  assign wr_b  = cmd_i.append_b && (cnt_b_q != CW'(LIST_DEPTH));
  assign has_a = (ptr_a_q < cnt_a_q);
  assign has_b = (ptr_b_q < cnt_b_q);

  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    sel_b  = 1'b0;
    priority if (has_a && has_b) begin
      if (head_a_q > head_b_q) begin
        take_b = 1'b1;
        sel_b  = 1'b1;
      end else if ((head_a_q < head_b_q) || !drop_q) begin
        take_a = 1'b1;
      end else begin
        take_a = 1'b1;
        take_b = 1'b1;
      end
    end else if (has_a) begin
      take_a = 1'b1;
    end else if (has_b) begin
      take_b = 1'b1;
      sel_b  = 1'b1;
    end else begin
      take_a = 1'b0;
    end
  end

  assign ptr_a_nx = ptr_a_q + CW'(take_a);
  assign ptr_b_nx = ptr_b_q + CW'(take_b);

  always_comb begin
    res.merged_value = sel_b ? head_b_q : head_a_q;
    res.from_second  = sel_b;
    res.last_of_run  = (ptr_a_nx == cnt_a_q) && (ptr_b_nx == cnt_b_q);
  end

  always_comb begin
    ptr_a_d = ptr_a_q;
    ptr_b_d = ptr_b_q;
    if (cmd_i.start) begin
      ptr_a_d = '0;
      ptr_b_d = '0;
    end else if (cmd_i.step) begin
      ptr_a_d = ptr_a_nx;
      ptr_b_d = ptr_b_nx;
    end
    cnt_a_d = cmd_i.finish ? '0 : (wr_a ? cnt_a_q + CW'(1) : cnt_a_q);
    cnt_b_d = cmd_i.finish ? '0 : (wr_b ? cnt_b_q + CW'(1) : cnt_b_q);
  end

  assign out_valid_d = cmd_i.step || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      ptr_a_q     <= '0;
      ptr_b_q     <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      ptr_a_q     <= ptr_a_d;
      ptr_b_q     <= ptr_b_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        drop_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[cnt_a_q[AW-1:0]] <= elem_i;
    end
    head_a_q <= mem_a[ptr_a_d[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      mem_b[cnt_b_q[AW-1:0]] <= elem_i;
    end
    head_b_q <= mem_b[ptr_b_d[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      out_q <= res;
    end
  end

  assign status_o.any_left  = has_a || has_b;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;
  assign status_o.last_step = res.last_of_run;
  assign out_valid_o        = out_valid_q;
  assign out_o              = out_q;

endmodule

/* hdl/sorted_list_merge_engine_top.sv */
`timescale 1ns / 1ps
// Two-list sorted merge engine. Commands append an element to list A or B
// (appends to a full list are dropped) or start a merge. A merge emits
// both lists in ascending signed order, A first on ties (or one copy when
// drop_q, written through cfg_we_i, is set), flags the final result with
// last_of_run, and then empties both lists. The merge issues one result per
// cycle while the output register drains; no command is taken while it
// runs. Each list store has a single read port.

`include "sorted_list_merge_engine_top_defines.svh"

module sorted_list_merge_engine_top #(
  parameter int unsigned LIST_DEPTH = slme_pkg::LIST_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  slme_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output slme_pkg::out_t out_o
);

  slme_pkg::dp_cmd_t    dp_cmd;
  slme_pkg::dp_status_t dp_status;

  slme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_i.cmd),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  slme_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .elem_i      (in_i.element_value),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

  `SLME_ASSERT(a_step_needs_room, dp_cmd.step |-> (!out_valid_o || !out_stall_i), "step overwrote pending result")
  `SLME_ASSERT(a_append_on_transfer, (dp_cmd.append_a || dp_cmd.append_b) |-> (in_valid_i && !in_stall_o), "append without input transfer")
  `SLME_ASSERT(a_no_step_after_last, (dp_cmd.step && dp_status.last_step) |=> !dp_cmd.step, "step after last result")

endmodule
